FILE: sv/otwd_pkg.sv
// Package for the three-wheel omni drive core: command and result item types,
// operation codes, and the elaboration-time sine table builder.
// Depends on nothing; used by the core top level and the testbench.
`timescale 1ns / 1ps

package otwd_pkg;

	// Operation codes of a drive command. Any other code acts as stop.
	localparam logic [1:0] OP_STOP      = 2'd0;
	localparam logic [1:0] OP_TRANSLATE = 2'd1;
	localparam logic [1:0] OP_ROTATE    = 2'd2;

	// Quadrant codes of the travel angle.
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Field widths fixed by the command and result formats.
	localparam int SPEED_W = 10;
	localparam int ANGLE_W = 9;
	localparam int QUO_W   = 10;

	// Angle constants in whole degrees.
	localparam logic [ANGLE_W-1:0] DEG_90   = 9'd90;
	localparam logic [ANGLE_W-1:0] DEG_180  = 9'd180;
	localparam logic [ANGLE_W-1:0] DEG_270  = 9'd270;
	localparam logic [ANGLE_W-1:0] DEG_360  = 9'd360;

	// Q2.30 constants used when the tables are built.
	localparam longint unsigned PI_Q30         = 64'd3373259426;
	localparam longint unsigned SQRT3_HALF_Q30 = 64'd929887697;

	typedef struct packed {
		logic [1:0]         operation;
		logic [ANGLE_W-1:0] angle_deg;
		logic [SPEED_W-1:0] speed;
		logic               rotate_ccw;
	} cmd_t;

	typedef struct packed {
		logic [7:0] wheel1_duty;
		logic       wheel1_reverse;
		logic [7:0] wheel2_duty;
		logic       wheel2_reverse;
		logic [7:0] wheel3_duty;
		logic       wheel3_reverse;
	} result_t;

	// Control that rides along the pipeline with each item.
	typedef struct packed {
		logic [1:0]         operation;
		logic [SPEED_W-1:0] rot_duty;
		logic               rotate_ccw;
	} ctl_t;

	// Control that rides along the divider stages.
	typedef struct packed {
		ctl_t       ctl;
		logic [2:0] neg;
		logic       mzero;
	} side_t;

	// Unsigned quotient by binary long division, one bit per loop pass.
	// Used by the table builder at elaboration only.
	function automatic longint unsigned udiv64(input longint unsigned n,
		input longint unsigned d);
		longint unsigned q;
		longint unsigned rm;
		q = '0;
		rm = '0;
		for (int b = 63; b >= 0; b--) begin
			rm = {rm[62:0], n[b]};
			if (rm >= d) begin
				rm = rm - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sine of k degrees (k up to 90) in Q1.frac, from a truncated Taylor series
	// in Q2.30, rounded half up and clamped to one. Used at elaboration only.
	function automatic longint unsigned sin_quarter(input int unsigned k,
		input int unsigned frac);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned dv;
		longint unsigned r;
		longint unsigned kk;
		longint sum;
		kk = (k > 90) ? 64'd90 : longint'(k);
		x = udiv64(kk * PI_Q30 + 64'd90, 64'd180);
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			case (n)
				1: dv = 64'd6;
				2: dv = 64'd20;
				3: dv = 64'd42;
				4: dv = 64'd72;
				5: dv = 64'd110;
				6: dv = 64'd156;
				default: dv = 64'd210;
			endcase
			term = udiv64((term * x2) >> 30, dv);
			if ((n & 1) != 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		r = (longint'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
		if (r > (64'd1 << frac)) begin
			r = 64'd1 << frac;
		end
		return r;
	endfunction

endpackage

FILE: sv/otwd_div.sv
// Pipelined restoring divider for the omni drive core: one quotient bit per
// stage, a new division may enter every cycle. Depends on nothing.
`timescale 1ns / 1ps

module otwd_div #(
	parameter int NUM_W = 42,
	parameter int DEN_W = 32,
	parameter int QUO_W = 10
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	// Working width: wide enough for the remainder and the shifted divisor,
	// plus a borrow bit.
	localparam int SPAN  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
	localparam int EXT_W = SPAN + 1;

	logic [NUM_W-1:0] rem_s [1:QUO_W];
	logic [DEN_W-1:0] den_s [1:QUO_W];
	logic [QUO_W-1:0] quo_s [1:QUO_W];

	logic [NUM_W-1:0] rem_in  [0:QUO_W-1];
	logic [DEN_W-1:0] den_in  [0:QUO_W-1];
	logic [QUO_W-1:0] quo_in  [0:QUO_W-1];
	logic [NUM_W-1:0] rem_nxt [0:QUO_W-1];
	logic [QUO_W-1:0] quo_nxt [0:QUO_W-1];
	logic [EXT_W-1:0] shifted [0:QUO_W-1];
	logic [EXT_W-1:0] diff    [0:QUO_W-1];

	// Each stage tries to take the divisor, shifted to its quotient bit, out of
	// the remainder; the quotient is known to fit in QUO_W bits.
	always_comb begin
		for (int i = 0; i < QUO_W; i++) begin
			if (i == 0) begin
				rem_in[i] = num;
				den_in[i] = den;
				quo_in[i] = '0;
			end else begin
				rem_in[i] = rem_s[i];
				den_in[i] = den_s[i];
				quo_in[i] = quo_s[i];
			end
			shifted[i] = EXT_W'(den_in[i]) << (QUO_W - 1 - i);
			diff[i] = EXT_W'(rem_in[i]) - shifted[i];
			rem_nxt[i] = rem_in[i];
			quo_nxt[i] = quo_in[i];
			if (!diff[i][EXT_W-1]) begin
				rem_nxt[i] = diff[i][NUM_W-1:0];
				quo_nxt[i][QUO_W-1-i] = 1'b1;
			end
		end
	end

	// Stage registers carry remainder, divisor and partial quotient.
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUO_W; i++) begin
			rem_s[i+1] <= rem_nxt[i];
			den_s[i+1] <= den_in[i];
			quo_s[i+1] <= quo_nxt[i];
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

FILE: sv/omni_three_wheel_drive_core.sv
// Top level of the three-wheel omni drive core: inverse kinematics from one
// drive command to three wheel duties and reverse bits.
// Depends on otwd_pkg and otwd_div.
`timescale 1ns / 1ps

// A command is taken on every clock edge where start is high; busy is always
// low, so a new command may follow in the very next cycle and the core runs
// one command per cycle indefinitely. Each command produces exactly one result,
// presented on result for a single cycle with done high and in command order.
// The pipeline is five stages of angle reduction, table lookup, weight multiply,
// weight sum and scale multiply, then ten stages of the restoring divider (one
// quotient bit each), then the output register. Results cannot be held off, so
// the receiver must take every result in the cycle it appears.
module omni_three_wheel_drive_core #(
	parameter int FRAC_BITS = 15,
	parameter int DUTY_MAX  = 255
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  otwd_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             done,
	output otwd_pkg::result_t result
);

	import otwd_pkg::*;

	// Table entries are unsigned Q1.F; sine and cosine are signed.
	localparam int SW       = FRAC_BITS + 1;
	localparam int SCW      = FRAC_BITS + 2;
	localparam int WW       = 2 * FRAC_BITS + 3;
	localparam int MW       = WW - 1;
	localparam int NW       = MW + SPEED_W;
	localparam int TAB_BITS = 91 * SW;
	localparam int LATENCY  = 5 + QUO_W + 1;

	localparam logic [SW-1:0] K_Q =
		SW'((SQRT3_HALF_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
	localparam logic [SPEED_W-1:0] DUTY_LIM = SPEED_W'(DUTY_MAX);

	function automatic logic [TAB_BITS-1:0] build_sin_tab();
		logic [TAB_BITS-1:0] t;
		t = '0;
		for (int k = 0; k <= 90; k++) begin
			t[k*SW +: SW] = SW'(sin_quarter(k, FRAC_BITS));
		end
		return t;
	endfunction

	localparam logic [TAB_BITS-1:0] SIN_TAB = build_sin_tab();

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: reduce the angle to a quadrant and an offset, clamp rotate duty.
	logic [ANGLE_W-1:0] a_mod;
	logic [ANGLE_W-1:0] a_off;
	logic [1:0]         quad;
	logic               v_s1;
	ctl_t               ctl_s1;
	logic [1:0]         quad_s1;
	logic [6:0]         r_s1;

	always_comb begin
		a_mod = (cmd.angle_deg >= DEG_360) ? cmd.angle_deg - DEG_360 : cmd.angle_deg;
		if (a_mod < DEG_90) begin
			quad  = QUAD_0;
			a_off = a_mod;
		end else if (a_mod < DEG_180) begin
			quad  = QUAD_1;
			a_off = a_mod - DEG_90;
		end else if (a_mod < DEG_270) begin
			quad  = QUAD_2;
			a_off = a_mod - DEG_180;
		end else begin
			quad  = QUAD_3;
			a_off = a_mod - DEG_270;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1.operation  <= cmd.operation;
		ctl_s1.rot_duty   <= (cmd.speed > DUTY_LIM) ? DUTY_LIM : cmd.speed;
		ctl_s1.rotate_ccw <= cmd.rotate_ccw;
		quad_s1           <= quad;
		r_s1              <= a_off[6:0];
	end

	// Stage 2: sine table lookups and quadrant symmetry.
	logic [6:0]            r_cmp;
	logic [SW-1:0]         sr;
	logic [SW-1:0]         sc;
	logic signed [SCW-1:0] sr_p;
	logic signed [SCW-1:0] sc_p;
	logic signed [SCW-1:0] s_nxt;
	logic signed [SCW-1:0] c_nxt;
	logic                  v_s2;
	ctl_t                  ctl_s2;
	logic [SPEED_W-1:0]    speed_s1;
	logic [SPEED_W-1:0]    speed_s2;
	logic signed [SCW-1:0] s_s2;
	logic signed [SCW-1:0] c_s2;

	always_ff @(posedge clk) begin
		speed_s1 <= cmd.speed;
	end

	always_comb begin
		r_cmp = 7'(DEG_90) - r_s1;
		sr    = SIN_TAB[r_s1 * SW +: SW];
		sc    = SIN_TAB[r_cmp * SW +: SW];
		sr_p  = $signed({1'b0, sr});
		sc_p  = $signed({1'b0, sc});
		case (quad_s1)
			QUAD_0: begin
				s_nxt = sr_p;
				c_nxt = sc_p;
			end
			QUAD_1: begin
				s_nxt = sc_p;
				c_nxt = -sr_p;
			end
			QUAD_2: begin
				s_nxt = -sr_p;
				c_nxt = -sc_p;
			end
			default: begin
				s_nxt = -sc_p;
				c_nxt = sr_p;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2   <= ctl_s1;
		speed_s2 <= speed_s1;
		s_s2     <= s_nxt;
		c_s2     <= c_nxt;
	end

	// Stage 3: cosine times sqrt(3)/2.
	logic signed [2*SCW-1:0] kc_full;
	logic                    v_s3;
	ctl_t                    ctl_s3;
	logic [SPEED_W-1:0]      speed_s3;
	logic signed [SCW-1:0]   s_s3;
	logic signed [WW-1:0]    kc_s3;

	assign kc_full = $signed({1'b0, K_Q}) * c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s3   <= ctl_s2;
		speed_s3 <= speed_s2;
		s_s3     <= s_s2;
		kc_s3    <= $signed(kc_full[WW-1:0]);
	end

	// Stage 4: the three wheel weights, split into magnitude and sign.
	logic signed [WW-1:0] s_ext;
	logic signed [WW-1:0] hs;
	logic signed [WW-1:0] w    [0:2];
	logic signed [WW-1:0] wabs [0:2];
	logic                 v_s4;
	ctl_t                 ctl_s4;
	logic [SPEED_W-1:0]   speed_s4;
	logic [MW-1:0]        mag_s4 [0:2];
	logic [2:0]           neg_s4;

	always_comb begin
		s_ext = WW'(s_s3);
		hs    = s_ext <<< (FRAC_BITS - 1);
		w[0]  = -(kc_s3 + hs);
		w[1]  = kc_s3 - hs;
		w[2]  = s_ext <<< FRAC_BITS;
		for (int i = 0; i < 3; i++) begin
			wabs[i] = w[i][WW-1] ? -w[i] : w[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s4   <= ctl_s3;
		speed_s4 <= speed_s3;
		for (int i = 0; i < 3; i++) begin
			mag_s4[i] <= wabs[i][MW-1:0];
			neg_s4[i] <= w[i][WW-1];
		end
	end

	// Stage 5: largest magnitude and the scaled numerators.
	logic [MW-1:0] m01;
	logic [MW-1:0] m_all;
	logic          v_s5;
	side_t         side_s5;
	logic [MW-1:0] m_s5;
	logic [NW-1:0] prod_s5 [0:2];

	always_comb begin
		m01   = (mag_s4[0] > mag_s4[1]) ? mag_s4[0] : mag_s4[1];
		m_all = (m01 > mag_s4[2]) ? m01 : mag_s4[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s5.ctl   <= ctl_s4;
		side_s5.neg   <= neg_s4;
		side_s5.mzero <= (m_all == '0);
		m_s5          <= m_all;
		for (int i = 0; i < 3; i++) begin
			prod_s5[i] <= NW'(mag_s4[i]) * NW'(speed_s4);
		end
	end

	// Divider stages: one lane per wheel, control rides alongside.
	logic [QUO_W-1:0] quo [0:2];
	logic             v_div [0:QUO_W-1];
	side_t            side_div [0:QUO_W-1];

	for (genvar g = 0; g < 3; g++) begin : g_lane
		otwd_div #(
			.NUM_W(NW),
			.DEN_W(MW),
			.QUO_W(QUO_W)
		) u_div (
			.clk(clk),
			.num(prod_s5[g]),
			.den(m_s5),
			.quo(quo[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUO_W; i++) begin
				v_div[i] <= 1'b0;
			end
		end else begin
			v_div[0] <= v_s5;
			for (int i = 1; i < QUO_W; i++) begin
				v_div[i] <= v_div[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_div[0] <= side_s5;
		for (int i = 1; i < QUO_W; i++) begin
			side_div[i] <= side_div[i-1];
		end
	end

	// Output stage: saturate, pick by operation, register the result.
	side_t            side_o;
	logic [QUO_W-1:0] duty_sat [0:2];
	logic [QUO_W-1:0] duty_sel [0:2];
	logic [2:0]       rev_sel;
	logic             done_q;
	result_t          result_q;

	assign side_o = side_div[QUO_W-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			duty_sat[i] = (quo[i] > DUTY_LIM) ? DUTY_LIM : quo[i];
			if (side_o.mzero) begin
				duty_sat[i] = '0;
			end
		end
		case (side_o.ctl.operation)
			OP_TRANSLATE: begin
				for (int i = 0; i < 3; i++) begin
					duty_sel[i] = duty_sat[i];
				end
				rev_sel = side_o.neg;
			end
			OP_ROTATE: begin
				for (int i = 0; i < 3; i++) begin
					duty_sel[i] = side_o.ctl.rot_duty;
				end
				rev_sel = {3{side_o.ctl.rotate_ccw}};
			end
			default: begin
				for (int i = 0; i < 3; i++) begin
					duty_sel[i] = '0;
				end
				rev_sel = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_div[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		result_q.wheel1_duty    <= duty_sel[0][7:0];
		result_q.wheel1_reverse <= rev_sel[0];
		result_q.wheel2_duty    <= duty_sel[1][7:0];
		result_q.wheel2_reverse <= rev_sel[1];
		result_q.wheel3_duty    <= duty_sel[2][7:0];
		result_q.wheel3_reverse <= rev_sel[2];
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// Every accepted command yields its result, with done high.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("command accepted but no result after pipeline latency");

	// No result appears without a command accepted at the matching edge.
	a_no_stray_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result strobe without a matching command");

	// Stop and unused operation codes give an all-zero result.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(cmd.operation != OP_TRANSLATE && cmd.operation != OP_ROTATE, LATENCY)
		|-> result == '0)
		else $error("stop command gave a nonzero wheel command");

	// Rotate drives all wheels alike with the requested sense.
	a_rotate_uniform: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(cmd.operation == OP_ROTATE, LATENCY)
		|-> result.wheel1_duty == result.wheel2_duty
			&& result.wheel2_duty == result.wheel3_duty
			&& result.wheel1_reverse == $past(cmd.rotate_ccw, LATENCY)
			&& result.wheel2_reverse == result.wheel1_reverse
			&& result.wheel3_reverse == result.wheel1_reverse)
		else $error("rotate command gave unequal wheel commands");
`endif

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for omni_three_wheel_drive_core: directed and random drive commands,
// each result checked field by field against a fixed or a kinematics-predicted expectation.
// Depends on otwd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
	import otwd_pkg::*;

	localparam int FRAC = 15;
	localparam int DUTY_LIMIT = 255;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int LATENCY = 16;
	localparam int RANDOM_ITEMS = 600;
	localparam int QUIET_TAIL = 100;
	localparam int MAX_REPORTS = 10;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		cmd_t    c;
		bit      typed;
		result_t want;
	} steer_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    done;
	result_t result;

	result_t    pending_wheels[$];
	steer_row_t steer_rows[$];
	int         errors = 0;
	int         results_seen = 0;
	int         items_sent = 0;
	int         n_translate = 0;
	int         n_rotate = 0;
	int         n_stop = 0;
	int         cycle_cnt = 0;

	omni_three_wheel_drive_core #(
		.FRAC_BITS(FRAC),
		.DUTY_MAX (DUTY_LIMIT)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	always #5 clk = ~clk;

	// Sine of a whole-degree angle in the first quadrant, Q1.FRAC, from a
	// truncated Taylor series in Q2.30 rounded half up.
	function automatic longint quarter_sine(input int unsigned deg);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned r;
		longint acc;
		int unsigned d;
		d = (deg > 90) ? 90 : deg;
		x = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		r = (unsigned'(acc) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
		if (r > (64'd1 << FRAC)) begin
			r = 64'd1 << FRAC;
		end
		return longint'(r);
	endfunction

	// Expected wheel commands for one drive command.
	function automatic result_t predict_wheels(input cmd_t c);
		result_t res;
		longint s;
		longint co;
		longint sr;
		longint sc;
		longint kq;
		longint w[3];
		longint unsigned mag[3];
		longint unsigned m;
		longint unsigned d[3];
		logic rev[3];
		int unsigned a;
		int unsigned rem;
		logic [1:0] quad;
		res = '0;
		case (c.operation)
			OP_ROTATE: begin
				d[0] = (c.speed > DUTY_LIMIT) ? DUTY_LIMIT : c.speed;
				res.wheel1_duty = d[0][7:0];
				res.wheel2_duty = d[0][7:0];
				res.wheel3_duty = d[0][7:0];
				res.wheel1_reverse = c.rotate_ccw;
				res.wheel2_reverse = c.rotate_ccw;
				res.wheel3_reverse = c.rotate_ccw;
			end
			OP_TRANSLATE: begin
				a = c.angle_deg % DEG_360;
				quad = 2'(a / DEG_90);
				rem = a % DEG_90;
				sr = quarter_sine(rem);
				sc = quarter_sine(90 - rem);
				case (quad)
					QUAD_0: begin s = sr;  co = sc;  end
					QUAD_1: begin s = sc;  co = -sr; end
					QUAD_2: begin s = -sr; co = -sc; end
					default: begin s = -sc; co = sr; end
				endcase
				kq = longint'((SQRT3_HALF_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
				w[0] = -(kq * co + s * (64'sd1 <<< (FRAC - 1)));
				w[1] = kq * co - s * (64'sd1 <<< (FRAC - 1));
				w[2] = s * (64'sd1 <<< FRAC);
				m = 0;
				for (int i = 0; i < 3; i++) begin
					mag[i] = (w[i] < 0) ? unsigned'(-w[i]) : unsigned'(w[i]);
					if (mag[i] > m) begin
						m = mag[i];
					end
				end
				// Scale by speed over the largest weight, truncate, saturate.
				for (int i = 0; i < 3; i++) begin
					d[i] = (m != 0) ? (mag[i] * 64'(c.speed)) / m : 64'd0;
					if (d[i] > DUTY_LIMIT) begin
						d[i] = DUTY_LIMIT;
					end
					rev[i] = (w[i] < 0);
				end
				res.wheel1_duty = d[0][7:0];
				res.wheel2_duty = d[1][7:0];
				res.wheel3_duty = d[2][7:0];
				res.wheel1_reverse = rev[0];
				res.wheel2_reverse = rev[1];
				res.wheel3_reverse = rev[2];
			end
			default: begin
				res = '0;
			end
		endcase
		return res;
	endfunction

	function automatic cmd_t mk_cmd(input logic [1:0] op, input int unsigned ang,
		input int unsigned spd, input logic ccw);
		cmd_t c;
		c.operation = op;
		c.angle_deg = ANGLE_W'(ang);
		c.speed = SPEED_W'(spd);
		c.rotate_ccw = ccw;
		return c;
	endfunction

	// All three wheels with the same duty and direction.
	function automatic result_t mk_same(input int unsigned duty, input logic rev);
		result_t r;
		r.wheel1_duty = 8'(duty);
		r.wheel2_duty = 8'(duty);
		r.wheel3_duty = 8'(duty);
		r.wheel1_reverse = rev;
		r.wheel2_reverse = rev;
		r.wheel3_reverse = rev;
		return r;
	endfunction

	// Random drive command, weighted toward translate and rotate.
	function automatic cmd_t rand_cmd();
		cmd_t c;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			c.operation = OP_TRANSLATE;
		end else if (pick < 80) begin
			c.operation = OP_ROTATE;
		end else if (pick < 90) begin
			c.operation = OP_STOP;
		end else begin
			c.operation = OP_UNUSED;
		end
		if ($urandom_range(0, 99) < 15) begin
			c.angle_deg = ANGLE_W'($urandom_range(360, 511));
		end else begin
			c.angle_deg = ANGLE_W'($urandom_range(0, 359));
		end
		case ($urandom_range(0, 9))
			0: c.speed = 10'd0;
			1: c.speed = 10'd1023;
			2: c.speed = SPEED_W'($urandom_range(254, 257));
			default: c.speed = SPEED_W'($urandom_range(0, 1023));
		endcase
		c.rotate_ccw = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Offer one item, hold it until accepted, then record what it should produce.
	task automatic send_item(input cmd_t c, input bit typed, input result_t want);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		pending_wheels.push_back(typed ? want : predict_wheels(c));
		items_sent++;
		case (c.operation)
			OP_TRANSLATE: n_translate++;
			OP_ROTATE: n_rotate++;
			default: n_stop++;
		endcase
	endtask

	// Sender gap: start low with junk on the command bus.
	task automatic idle_burst(input int cycles);
		start <= 1'b0;
		cmd <= rand_cmd();
		repeat (cycles) @(posedge clk);
	endtask

	task automatic check_field(input string fname, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("mismatch on result %0d, %s: expected %0d, got %0d",
					results_seen, fname, want, got);
			end
		end
	endtask

	// Every strobed result must match the oldest expectation.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (pending_wheels.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("result with nothing expected: %h", result);
				end
			end else begin
				want = pending_wheels.pop_front();
				check_field("wheel1_duty", want.wheel1_duty, result.wheel1_duty);
				check_field("wheel1_reverse", want.wheel1_reverse, result.wheel1_reverse);
				check_field("wheel2_duty", want.wheel2_duty, result.wheel2_duty);
				check_field("wheel2_reverse", want.wheel2_reverse, result.wheel2_reverse);
				check_field("wheel3_duty", want.wheel3_duty, result.wheel3_duty);
				check_field("wheel3_reverse", want.wheel3_reverse, result.wheel3_reverse);
			end
			results_seen++;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("omni_three_wheel_drive_core regression: fail");
			$finish;
		end
	end

	initial begin
		int waited;
		bit calm;
		// Directed commands: stop with all fields zero and with high fields, the unused
		// code with every field at its top, rotate at the speed extremes and around
		// saturation, translate at the axes, out-of-range angles and near the weight zero crossings.
		steer_rows.push_back('{mk_cmd(OP_STOP, 359, 1023, 1'b1), 1'b1, mk_same(0, 1'b0)});
		steer_rows.push_back('{mk_cmd(OP_STOP, 0, 0, 1'b0), 1'b1, mk_same(0, 1'b0)});
		steer_rows.push_back('{mk_cmd(OP_UNUSED, 511, 1023, 1'b1), 1'b1, mk_same(0, 1'b0)});
		steer_rows.push_back('{mk_cmd(OP_ROTATE, 0, 0, 1'b0), 1'b1, mk_same(0, 1'b0)});
		steer_rows.push_back('{mk_cmd(OP_ROTATE, 0, 1023, 1'b1), 1'b1, mk_same(255, 1'b1)});
		steer_rows.push_back('{mk_cmd(OP_ROTATE, 511, 255, 1'b0), 1'b1, mk_same(255, 1'b0)});
		steer_rows.push_back('{mk_cmd(OP_ROTATE, 0, 256, 1'b1), 1'b1, mk_same(255, 1'b1)});
		steer_rows.push_back('{mk_cmd(OP_ROTATE, 123, 100, 1'b1), 1'b1, mk_same(100, 1'b1)});
		steer_rows.push_back('{mk_cmd(OP_ROTATE, 0, 1, 1'b0), 1'b1, mk_same(1, 1'b0)});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 0, 0, 1'b0), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 0, 1023, 1'b1), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 90, 1023, 1'b0), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 180, 255, 1'b0), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 270, 200, 1'b0), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 359, 1023, 1'b0), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 360, 150, 1'b0), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 511, 1023, 1'b1), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 60, 1, 1'b0), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 30, 100, 1'b0), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 150, 800, 1'b1), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 240, 300, 1'b0), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 330, 511, 1'b0), 1'b0, '0});
		steer_rows.push_back('{mk_cmd(OP_TRANSLATE, 45, 256, 1'b1), 1'b0, '0});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steer_rows[i]) begin
			send_item(steer_rows[i].c, steer_rows[i].typed, steer_rows[i].want);
		end

		// Random commands; idling comes in bursts, some stretches run back to back,
		// and the tail of the run has no gaps at all.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				start <= 1'b0;
				do @(posedge clk); while (pending_wheels.size() != 0);
			end
			calm = ((n / 50) % 3 == 2) || (n >= RANDOM_ITEMS - QUIET_TAIL);
			if (!calm && $urandom_range(0, 99) < 30) begin
				idle_burst($urandom_range(1, 18));
			end
			send_item(rand_cmd(), 1'b0, '0);
		end
		start <= 1'b0;

		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending_wheels.size() != 0 && waited < 10 * LATENCY);
		repeat (LATENCY + 4) @(posedge clk);

		if (pending_wheels.size() != 0) begin
			errors += pending_wheels.size();
			$display("%0d expected results never arrived", pending_wheels.size());
		end
		$display("%0d drive commands sent (%0d translate, %0d rotate, %0d stop or unused),",
			items_sent, n_translate, n_rotate, n_stop);
		$display("%0d wheel results checked, %0d field mismatches", results_seen, errors);
		if (errors == 0) begin
			$display("omni_three_wheel_drive_core regression: pass");
		end else begin
			$display("omni_three_wheel_drive_core regression: fail");
		end
		$finish;
	end

endmodule
